// File: rtl/core/lcdw_pkg.sv
// Shared types and constants for the three-wire LCD write serializer.
package lcdw_pkg;

	localparam int unsigned FrameBits = 12;
	localparam int unsigned CntW      = $clog2(FrameBits + 1);

	typedef enum logic [1:0] {
		CMD_COMMAND = 2'd0,
		CMD_START   = 2'd1,
		CMD_NIBBLE  = 2'd2
	} cmd_t;

	localparam logic [2:0] HDR_COMMAND = 3'b100;
	localparam logic [2:0] HDR_WRITE   = 3'b101;

	localparam logic [CntW-1:0] LEN_COMMAND = CntW'(12);
	localparam logic [CntW-1:0] LEN_START   = CntW'(9);
	localparam logic [CntW-1:0] LEN_NIBBLE  = CntW'(4);

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] value;
		logic       end_frame;
	} req_t;

	typedef struct packed {
		logic bit_value;
		logic frame_start;
		logic frame_end;
		logic last;
	} rsp_t;

	// one decoded request, bits sent from the MSB down
	typedef struct packed {
		logic                 drop;
		logic [FrameBits-1:0] bits;
		logic [CntW-1:0]      len;
		logic                 fs;
		logic                 fe;
	} frame_t;

endpackage

// File: rtl/core/lcdw_decode.sv
// Request decoder: builds the bit frame for a word and tracks the open data frame.
module lcdw_decode import lcdw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   req,
	input  logic   take,
	output frame_t frame
);

	logic frame_open_q;
	logic open_nxt;

	always_comb begin
		frame     = '0;
		frame.drop = 1'b1;
		open_nxt  = frame_open_q;
		case (req.command)
			CMD_COMMAND: begin
				if (!frame_open_q) begin
					frame.drop = 1'b0;
					frame.bits = {HDR_COMMAND, req.value, 1'b0};
					frame.len  = LEN_COMMAND;
					frame.fs   = 1'b1;
					frame.fe   = 1'b1;
				end
			end
			CMD_START: begin
				if (!frame_open_q) begin
					frame.drop = 1'b0;
					frame.bits = {HDR_WRITE, req.value[5:0], 3'b000};
					frame.len  = LEN_START;
					frame.fs   = 1'b1;
					open_nxt   = 1'b1;
				end
			end
			CMD_NIBBLE: begin
				if (frame_open_q) begin
					frame.drop = 1'b0;
					frame.bits = {req.value[0], req.value[1], req.value[2], req.value[3],
						8'h00};
					frame.len  = LEN_NIBBLE;
					frame.fe   = req.end_frame;
					open_nxt   = !req.end_frame;
				end
			end
			default: begin
				frame.drop = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (take) begin
			frame_open_q <= open_nxt;
		end
	end

endmodule

// File: rtl/core/lcdw_serial.sv
// Frame shifter and result register: one bit out per cycle while the result register is not stalled.
module lcdw_serial import lcdw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  frame_t frame,
	input  logic   load,
	output logic   can_load,
	output logic   rsp_valid,
	input  logic   rsp_ready,
	output rsp_t   rsp
);

	logic [FrameBits-1:0] sh_q;
	logic [CntW-1:0]      cnt_q;
	logic                 fs_q;
	logic                 fe_q;
	logic                 emit;
	logic                 at_last;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	assign at_last  = (cnt_q == CntW'(1));
	assign emit     = (cnt_q != '0) && (!rsp_valid_q || rsp_ready);
	assign can_load = (cnt_q == '0) || (emit && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fs_q  <= 1'b0;
			fe_q  <= 1'b0;
		end else if (load) begin
			cnt_q <= frame.len;
			fs_q  <= frame.fs;
			fe_q  <= frame.fe;
		end else if (emit) begin
			cnt_q <= cnt_q - CntW'(1);
			fs_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= frame.bits;
		end else if (emit) begin
			sh_q <= {sh_q[FrameBits-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.bit_value   <= sh_q[FrameBits-1];
			rsp_q.frame_start <= fs_q;
			rsp_q.frame_end   <= fe_q && at_last;
			rsp_q.last        <= at_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/lcd_driver_three_wire_writer.sv
// Top level of the three-wire LCD write serializer.
//
//  channel | dir | handshake            | word
//  req     | in  | req_valid/req_ready  | req_t: command, value, end_frame
//  rsp     | out | rsp_valid/rsp_ready  | rsp_t: bit_value, frame_start, frame_end, last
//
// One bit leaves per cycle from the frame shifter while rsp is not stalled: a command sends 12 bits,
// a data start 9, a nibble 4; a dropped word sends nothing.
// The next word is taken in the cycle the previous word's last bit is sent.
// Reset clears the open-frame flag and empties the shifter and result register.
// A stalled rsp holds its word and stops the shifter, and with it req_ready while the shifter holds bits.
module lcd_driver_three_wire_writer import lcdw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	frame_t frame;
	logic   take;
	logic   can_load;

	assign req_ready = can_load;
	assign take      = req_valid && req_ready;

	lcdw_decode u_decode (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.take  (take),
		.frame (frame)
	);

	lcdw_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.load     (take && !frame.drop),
		.can_load (can_load),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/lcdw_checker.sv
// Port-level checks for the three-wire LCD write serializer, bound to the top level.
module lcdw_checker import lcdw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_end |-> rsp.last)
		else $error("chip select rise not on last bit");

	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_start |-> !rsp.last)
		else $error("frame start on last bit");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=> rsp_valid)
		else $error("gap inside one word's bits");

endmodule

bind lcd_driver_three_wire_writer lcdw_checker u_lcdw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
